### design/abms_pkg.sv
// Shared types and constants for the alarm bank with match and snooze.
// No dependencies; used by abms_cell, abms_ctrl and the top level.
`timescale 1ns / 1ps

package abms_pkg;

  localparam int NumAlarmsDef = 8;
  localparam int NumAlarmsMax = 64;
  localparam int IdxMaxW      = 6;

  localparam logic [3:0] SnoozeLimitRst = 4'd5;

  localparam int HourMax    = 23;
  localparam int MinuteMax  = 59;
  localparam int SecondMax  = 59;
  localparam int MinPerHour = 60;
  localparam int HrPerDay   = 24;
  // floor(2^16 / 60); quotient may come out one low, fixed by one compare
  localparam int Recip60    = 1092;

  typedef enum logic [2:0] {
    FN_TICK   = 3'd0,
    FN_PREV   = 3'd1,
    FN_NEXT   = 3'd2,
    FN_TOGGLE = 3'd3,
    FN_SET    = 3'd4,
    FN_DELETE = 3'd5,
    FN_SNOOZE = 3'd6
  } func_e;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } tod_t;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic       en;
  } alarm_t;

  // match token walking the cell row
  typedef struct packed {
    logic               valid;
    logic               found;
    logic [IdxMaxW-1:0] idx;
  } tok_t;

  // write command broadcast to all cells
  typedef struct packed {
    logic               en;
    logic [IdxMaxW-1:0] idx;
    alarm_t             data;
  } wr_t;

endpackage

### design/abms_cell.sv
// One alarm cell: holds one alarm, passes the match token to its neighbor.
// Depends on abms_pkg.
`timescale 1ns / 1ps

module abms_cell import abms_pkg::*; #(
  parameter int CellIdx = 0
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  tod_t   now_i,
  input  wr_t    wr_i,
  input  tok_t   tok_i,
  output tok_t   tok_o,
  output alarm_t alarm_o
);

  alarm_t alarm_q, alarm_d;
  tok_t   tok_q, tok_d;
  logic   match;

  assign match = alarm_q.en && (alarm_q.hour == now_i.hour) &&
                 (alarm_q.minute == now_i.minute) && (alarm_q.second == now_i.second);

  always_comb begin
    tok_d = tok_i;
    // first match upstream wins
    if (!tok_i.found && match) begin
      tok_d.found = 1'b1;
      tok_d.idx   = IdxMaxW'(CellIdx);
    end
    alarm_d = alarm_q;
    if (wr_i.en && (wr_i.idx == IdxMaxW'(CellIdx))) begin
      alarm_d = wr_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alarm_q <= '0;
      tok_q   <= '0;
    end else begin
      alarm_q <= alarm_d;
      tok_q   <= tok_d;
    end
  end

  assign tok_o   = tok_q;
  assign alarm_o = alarm_q;

endmodule

### design/abms_ctrl.sv
// Sequencer: captures a command beat, launches the match token, does the
// snooze arithmetic, commits writes and drives the result. Depends on abms_pkg.
`timescale 1ns / 1ps

module abms_ctrl import abms_pkg::*; #(
  parameter int NUM_ALARMS = NumAlarmsDef,
  localparam int IdxW      = (NUM_ALARMS > 1) ? $clog2(NUM_ALARMS) : 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  logic [2:0]      func_i,
  input  logic [4:0]      time_hour_i,
  input  logic [5:0]      time_minute_i,
  input  logic [5:0]      time_second_i,
  input  logic [10:0]     snooze_minutes_i,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [3:0]      cfg_data_i,
  output logic            done_o,
  output logic            status_o,
  output logic            alarm_hit_o,
  output logic [IdxW-1:0] hit_index_o,
  output logic [IdxW-1:0] selected_index_o,
  output logic [4:0]      sel_hour_o,
  output logic [5:0]      sel_minute_o,
  output logic [5:0]      sel_second_o,
  output logic            sel_enabled_o,
  output logic [3:0]      snoozes_used_o,
  input  alarm_t          alarms_i [NUM_ALARMS],
  output tod_t            now_o,
  output wr_t             wr_o,
  output tok_t            tok_o,
  input  tok_t            tok_i
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESP
  } state_e;

  state_e          state_q;
  logic            launch_q;
  logic            launch2_q;
  logic [IdxW-1:0] sel_q, sel_d;
  logic [3:0]      cnt_q, cnt_d;
  logic [3:0]      limit_q;
  logic            status_q, status_d;
  logic            hit_q, hit_d;
  logic [IdxW-1:0] hit_idx_q, hit_idx_d;
  logic            done_q;
  logic [4:0]      sel_hour_q;
  logic [5:0]      sel_minute_q, sel_second_q;
  logic            sel_en_q;

  // captured command beat
  func_e       func_q;
  logic [4:0]  hour_q;
  logic [5:0]  minute_q, second_q;
  logic [10:0] add_q;

  // snooze arithmetic
  logic [11:0] total_c, total_q;
  logic [21:0] prod_q;
  logic [5:0]  quo_c, quo_fix;
  logic [11:0] rem_c, rem_fix;
  logic [6:0]  hsum_q;
  logic [5:0]  mn_q;
  logic [4:0]  hour_mod;
  logic [5:0]  sec_fix;

  logic   accept, commit;
  alarm_t cur;
  wr_t    wr_d;

  assign accept      = start && (state_q == S_IDLE);
  assign commit      = (state_q == S_SCAN) && tok_i.valid;
  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  assign total_c = 12'(minute_q) + 12'(add_q);
  assign quo_c   = prod_q[21:16];
  assign rem_c   = total_q - ((12'(quo_c) << 6) - (12'(quo_c) << 2));

  always_comb begin
    quo_fix = quo_c;
    rem_fix = rem_c;
    if (rem_c >= 12'(MinPerHour)) begin
      quo_fix = quo_c + 6'd1;
      rem_fix = rem_c - 12'(MinPerHour);
    end
  end

  always_comb begin
    priority if (hsum_q >= 7'(2 * HrPerDay)) begin
      hour_mod = 5'(hsum_q - 7'(2 * HrPerDay));
    end else if (hsum_q >= 7'(HrPerDay)) begin
      hour_mod = 5'(hsum_q - 7'(HrPerDay));
    end else begin
      hour_mod = 5'(hsum_q);
    end
  end

  assign sec_fix = (second_q >= 6'(MinPerHour)) ? (second_q - 6'(MinPerHour)) : second_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q   <= func_e'(func_i);
      hour_q   <= time_hour_i;
      minute_q <= time_minute_i;
      second_q <= time_second_i;
      add_q    <= snooze_minutes_i;
    end
    total_q <= total_c;
    prod_q  <= 22'(total_c) * 22'(Recip60);
    hsum_q  <= 7'(hour_q) + 7'(quo_fix);
    mn_q    <= rem_fix[5:0];
  end

  assign cur   = alarms_i[sel_q];
  assign now_o = '{hour: hour_q, minute: minute_q, second: second_q};

  always_comb begin
    sel_d     = sel_q;
    cnt_d     = cnt_q;
    status_d  = 1'b0;
    hit_d     = 1'b0;
    hit_idx_d = '0;
    wr_d      = '0;
    wr_d.idx  = IdxMaxW'(sel_q);
    wr_d.data = cur;
    unique case (func_q)
      FN_TICK: begin
        if (tok_i.found) begin
          hit_d     = 1'b1;
          hit_idx_d = tok_i.idx[IdxW-1:0];
          sel_d     = tok_i.idx[IdxW-1:0];
        end
      end
      FN_PREV: begin
        if (sel_q != '0) sel_d = sel_q - IdxW'(1);
      end
      FN_NEXT: begin
        if (sel_q != IdxW'(NUM_ALARMS - 1)) sel_d = sel_q + IdxW'(1);
      end
      FN_TOGGLE: begin
        wr_d.en      = 1'b1;
        wr_d.data.en = ~cur.en;
      end
      FN_SET: begin
        if ((hour_q > 5'(HourMax)) || (minute_q > 6'(MinuteMax)) ||
            (second_q > 6'(SecondMax))) begin
          status_d = 1'b1;
        end else begin
          wr_d.en   = 1'b1;
          wr_d.data = '{hour: hour_q, minute: minute_q, second: second_q, en: 1'b1};
        end
      end
      FN_DELETE: begin
        wr_d.en   = 1'b1;
        wr_d.data = '0;
      end
      FN_SNOOZE: begin
        wr_d.en = 1'b1;
        if (cnt_q >= limit_q) begin
          cnt_d        = '0;
          wr_d.data.en = 1'b0;
        end else begin
          cnt_d     = cnt_q + 4'd1;
          wr_d.data = '{hour: hour_mod, minute: mn_q, second: sec_fix, en: cur.en};
        end
      end
      default: ;
    endcase
    wr_d.en = wr_d.en && commit;
  end

  assign wr_o = wr_d;
  // a single-cell row returns the token before the snooze math settles
  assign tok_o = '{valid: (NUM_ALARMS > 1) ? launch_q : launch2_q, found: 1'b0, idx: '0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      launch_q     <= 1'b0;
      launch2_q    <= 1'b0;
      sel_q        <= '0;
      cnt_q        <= '0;
      limit_q      <= SnoozeLimitRst;
      status_q     <= 1'b0;
      hit_q        <= 1'b0;
      hit_idx_q    <= '0;
      done_q       <= 1'b0;
      sel_hour_q   <= '0;
      sel_minute_q <= '0;
      sel_second_q <= '0;
      sel_en_q     <= 1'b0;
    end else begin
      launch_q  <= accept;
      launch2_q <= launch_q;
      done_q    <= 1'b0;
      if (cfg_valid_i) limit_q <= cfg_data_i;
      unique case (state_q)
        S_IDLE: begin
          if (start) state_q <= S_SCAN;
        end
        S_SCAN: begin
          if (tok_i.valid) begin
            sel_q     <= sel_d;
            cnt_q     <= cnt_d;
            status_q  <= status_d;
            hit_q     <= hit_d;
            hit_idx_q <= hit_idx_d;
            state_q   <= S_RESP;
          end
        end
        S_RESP: begin
          // cells already hold the committed values
          sel_hour_q   <= cur.hour;
          sel_minute_q <= cur.minute;
          sel_second_q <= cur.second;
          sel_en_q     <= cur.en;
          done_q       <= 1'b1;
          state_q      <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign done_o           = done_q;
  assign status_o         = status_q;
  assign alarm_hit_o      = hit_q;
  assign hit_index_o      = hit_idx_q;
  assign selected_index_o = sel_q;
  assign sel_hour_o       = sel_hour_q;
  assign sel_minute_o     = sel_minute_q;
  assign sel_second_o     = sel_second_q;
  assign sel_enabled_o    = sel_en_q;
  assign snoozes_used_o   = cnt_q;

  a_tok_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_i.valid |-> (state_q == S_SCAN))
    else $error("match token left the row outside a scan");

  a_sel_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $unsigned(sel_q) < NUM_ALARMS)
    else $error("selection beyond the bank");

  a_hit_selects: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && alarm_hit_o) |-> (selected_index_o == hit_index_o))
    else $error("hit did not move the selection");

  a_status_no_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_o |-> !alarm_hit_o)
    else $error("reject and hit in one beat");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held more than one cycle");

endmodule

### design/alarm_bank_match_snooze.sv
// Top level of the alarm bank: a row of alarm cells and the sequencer.
// Depends on abms_pkg, abms_cell, abms_ctrl.
`timescale 1ns / 1ps
//
//  channel   handshake                        payload
//  command   start / busy (taken when !busy)  func, time_hour/minute/second, snooze_minutes
//  result    done_o strobe, one cycle         status .. snoozes_used
//  config    cfg_valid_i / cfg_ready_o        cfg_data_i (snooze limit)
//
// In each command beat the match token walks the cell row one cell per cycle
// (a single-cell row delays its launch through launch2_q to let the snooze
// math settle), then the sequencer commits the update in S_SCAN and registers
// the result in S_RESP. busy is high from the accept edge until the result
// strobe, when a new beat may be taken at once.
// Reset clears every alarm, the selection and the snooze count; the limit
// returns to 5. The result is shown for one cycle and cannot be held off.

module alarm_bank_match_snooze import abms_pkg::*; #(
  parameter int NUM_ALARMS = NumAlarmsDef,
  localparam int IdxW      = (NUM_ALARMS > 1) ? $clog2(NUM_ALARMS) : 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  logic [2:0]      func_i,
  input  logic [4:0]      time_hour_i,
  input  logic [5:0]      time_minute_i,
  input  logic [5:0]      time_second_i,
  input  logic [10:0]     snooze_minutes_i,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [3:0]      cfg_data_i,
  output logic            done_o,
  output logic            status_o,
  output logic            alarm_hit_o,
  output logic [IdxW-1:0] hit_index_o,
  output logic [IdxW-1:0] selected_index_o,
  output logic [4:0]      sel_hour_o,
  output logic [5:0]      sel_minute_o,
  output logic [5:0]      sel_second_o,
  output logic            sel_enabled_o,
  output logic [3:0]      snoozes_used_o
);

  alarm_t alarms [NUM_ALARMS];
  tok_t   tok_chain [NUM_ALARMS+1];
  tod_t   now;
  wr_t    wr;

  abms_ctrl #(
    .NUM_ALARMS(NUM_ALARMS)
  ) u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .func_i           (func_i),
    .time_hour_i      (time_hour_i),
    .time_minute_i    (time_minute_i),
    .time_second_i    (time_second_i),
    .snooze_minutes_i (snooze_minutes_i),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .done_o           (done_o),
    .status_o         (status_o),
    .alarm_hit_o      (alarm_hit_o),
    .hit_index_o      (hit_index_o),
    .selected_index_o (selected_index_o),
    .sel_hour_o       (sel_hour_o),
    .sel_minute_o     (sel_minute_o),
    .sel_second_o     (sel_second_o),
    .sel_enabled_o    (sel_enabled_o),
    .snoozes_used_o   (snoozes_used_o),
    .alarms_i         (alarms),
    .now_o            (now),
    .wr_o             (wr),
    .tok_o            (tok_chain[0]),
    .tok_i            (tok_chain[NUM_ALARMS])
  );

  for (genvar i = 0; i < NUM_ALARMS; i++) begin : g_cell
    abms_cell #(
      .CellIdx(i)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .now_i   (now),
      .wr_i    (wr),
      .tok_i   (tok_chain[i]),
      .tok_o   (tok_chain[i+1]),
      .alarm_o (alarms[i])
    );
  end

endmodule
